[rtl/crle_pkg.sv]
// ----------------------------------------------------------------------------
// crle_pkg
// Shared types, constants and arithmetic helpers for the closed-loop
// Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package crle_pkg;

    localparam int LOOP_POINTS_DEF = 5;
    localparam int CURVE_COUNT_DEF = 8;
    localparam int COORD_BITS_DEF  = 16;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_BITS  = 3;
    localparam int CURVE_BITS = 3;
    localparam int IN_W       = 16;
    localparam int FRAC_W     = 16;
    localparam int OUT_W      = 24;
    localparam int H_W        = 22;
    localparam int PROD_W     = H_W + FRAC_W + 1;
    localparam int FETCH_LAT  = 2;
    localparam int LANE_LAT   = 5;
    localparam int TOTAL_LAT  = FETCH_LAT + LANE_LAT;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

    typedef logic signed [IN_W-1:0]   t_coord;
    typedef logic signed [H_W-1:0]    t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [OUT_W-1:0]  t_out;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctrl;

    // round half up, drop the fraction bits
    function automatic t_acc round16(input t_prod x);
        logic signed [PROD_W:0] sum;
        sum = $signed({x[PROD_W-1], x}) + $signed((PROD_W+1)'(1 << (FRAC_W - 1)));
        return t_acc'(sum >>> FRAC_W);
    endfunction

    // floor((h + 1) / 2), widened to the output format
    function automatic t_out half_up(input t_acc h);
        logic signed [H_W:0] sum;
        sum = $signed({h[H_W-1], h}) + $signed((H_W+1)'(1));
        return t_out'(sum >>> 1);
    endfunction

endpackage

[rtl/crle_ram.sv]
// ----------------------------------------------------------------------------
// crle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crle_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/crle_fetch.sv]
// ----------------------------------------------------------------------------
// crle_fetch
// Point store writes, segment selection and the four-point read through
// replicated point-store RAMs.
// ----------------------------------------------------------------------------
module crle_fetch #(
    parameter int LOOP_POINTS = crle_pkg::LOOP_POINTS_DEF,
    parameter int CURVE_COUNT = crle_pkg::CURVE_COUNT_DEF,
    parameter int COORD_BITS  = crle_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_cmd,
    input  logic [crle_pkg::CURVE_BITS-1:0] i_curve,
    input  logic [crle_pkg::SLOT_BITS-1:0]  i_point_index,
    input  crle_pkg::t_coord                i_coord [3],
    input  logic [crle_pkg::FRAC_W-1:0]     i_global_t,
    output crle_pkg::t_ctrl                 o_ctrl,
    output logic [crle_pkg::FRAC_W-1:0]     o_frac,
    output crle_pkg::t_coord                o_pt [4][3]
);

    localparam int DEPTH  = CURVE_COUNT * crle_pkg::SLOT_COUNT;
    localparam int AW     = $clog2(DEPTH);
    localparam int FULL_W = 1 + crle_pkg::CURVE_BITS + crle_pkg::SLOT_BITS;
    localparam int ROW_W  = 3 * COORD_BITS;
    localparam int S_W    = crle_pkg::FRAC_W + 4;

    logic [S_W-1:0]   w_s;
    logic             w_curve_ok;
    logic             w_slot_ok;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [ROW_W-1:0] w_wdata;
    logic [3:0]       w_seg_p1;
    logic [3:0]       w_seg_p2;
    logic [crle_pkg::SLOT_BITS-1:0] w_idx [4];
    logic [AW-1:0]    w_raddr [4];
    logic [ROW_W-1:0] w_rdata [4];

    crle_pkg::t_ctrl                 r1_ctrl;
    logic [crle_pkg::SLOT_BITS-1:0]  r1_seg;
    logic [crle_pkg::FRAC_W-1:0]     r1_frac;
    logic [crle_pkg::CURVE_BITS-1:0] r1_curve;
    crle_pkg::t_ctrl                 r2_ctrl;
    logic [crle_pkg::FRAC_W-1:0]     r2_frac;

    assign w_s        = S_W'(i_global_t) * S_W'(LOOP_POINTS);
    assign w_curve_ok = 5'(i_curve) < 5'(CURVE_COUNT);
    assign w_slot_ok  = 4'(i_point_index) < 4'(LOOP_POINTS);
    assign w_we       = i_accept && (i_cmd == crle_pkg::CMD_WRITE) && w_curve_ok && w_slot_ok;
    assign w_waddr    = AW'(FULL_W'({1'b0, i_curve, i_point_index}));
    assign w_wdata    = {COORD_BITS'($signed(i_coord[2])),
                         COORD_BITS'($signed(i_coord[1])),
                         COORD_BITS'($signed(i_coord[0]))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
            r2_ctrl <= '0;
        end else begin
            r1_ctrl.valid <= i_accept && (i_cmd == crle_pkg::CMD_EVAL);
            r1_ctrl.zero  <= !w_curve_ok;
            r2_ctrl       <= r1_ctrl;
        end
        r1_seg   <= w_s[crle_pkg::FRAC_W +: crle_pkg::SLOT_BITS];
        r1_frac  <= w_s[crle_pkg::FRAC_W-1:0];
        r1_curve <= i_curve;
        r2_frac  <= r1_frac;
    end

    // neighbors of the segment, wrapped around the loop
    assign w_seg_p1 = 4'(r1_seg) + 4'd1;
    assign w_seg_p2 = 4'(r1_seg) + 4'd2;

    always_comb begin
        w_idx[0] = (r1_seg == '0) ? crle_pkg::SLOT_BITS'(LOOP_POINTS - 1) : r1_seg - 1'b1;
        w_idx[1] = r1_seg;
        w_idx[2] = (w_seg_p1 >= 4'(LOOP_POINTS)) ? '0 : w_seg_p1[crle_pkg::SLOT_BITS-1:0];
        w_idx[3] = (w_seg_p2 >= 4'(LOOP_POINTS)) ?
                   crle_pkg::SLOT_BITS'(w_seg_p2 - 4'(LOOP_POINTS)) :
                   w_seg_p2[crle_pkg::SLOT_BITS-1:0];
    end

    for (genvar k = 0; k < 4; k++) begin : g_copy
        assign w_raddr[k] = AW'(FULL_W'({1'b0, r1_curve, w_idx[k]}));

        crle_ram #(
            .WIDTH (ROW_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr[k]),
            .o_rdata (w_rdata[k])
        );

        for (genvar c = 0; c < 3; c++) begin : g_axis
            assign o_pt[k][c] =
                crle_pkg::IN_W'($signed(w_rdata[k][c*COORD_BITS +: COORD_BITS]));
        end
    end

    assign o_ctrl = r2_ctrl;
    assign o_frac = r2_frac;

endmodule

[rtl/crle_lane.sv]
// ----------------------------------------------------------------------------
// crle_lane
// One coordinate of the basis: coefficient forming, then Horner steps for
// position and derivative, each with at most one multiply per stage.
// ----------------------------------------------------------------------------
module crle_lane (
    input  logic                        i_clk,
    input  crle_pkg::t_coord            i_p0,
    input  crle_pkg::t_coord            i_p1,
    input  crle_pkg::t_coord            i_p2,
    input  crle_pkg::t_coord            i_p3,
    input  logic [crle_pkg::FRAC_W-1:0] i_frac,
    output crle_pkg::t_out              o_pos,
    output crle_pkg::t_out              o_der
);

    localparam int FS_W = crle_pkg::FRAC_W + 1;

    crle_pkg::t_acc w_q0, w_q1, w_q2, w_q3;
    crle_pkg::t_acc n_a, n_a3, n_b, n_b2, n_c, n_p2;
    crle_pkg::t_acc n_hb, n_gb, n_hc, n_h;
    logic signed [FS_W-1:0] w_f1, w_f2, w_f3;

    crle_pkg::t_acc  r1_a, r1_a3, r1_b, r1_b2, r1_c, r1_p2;
    logic [crle_pkg::FRAC_W-1:0] r1_frac, r2_frac, r3_frac;
    crle_pkg::t_prod r2_pa, r2_ga;
    crle_pkg::t_acc  r2_b, r2_b2, r2_c, r2_p2;
    crle_pkg::t_prod r3_pb, r3_gb;
    crle_pkg::t_acc  r3_c, r3_p2;
    crle_pkg::t_prod r4_pc;
    crle_pkg::t_acc  r4_g, r4_p2;
    crle_pkg::t_out  r5_pos, r5_der;

    always_comb begin
        w_q0 = crle_pkg::t_acc'(i_p0);
        w_q1 = crle_pkg::t_acc'(i_p1);
        w_q2 = crle_pkg::t_acc'(i_p2);
        w_q3 = crle_pkg::t_acc'(i_p3);
        n_a  = crle_pkg::t_acc'(-w_q0 + 3 * w_q1 - 3 * w_q2 + w_q3);
        n_a3 = crle_pkg::t_acc'(3 * n_a);
        n_b  = crle_pkg::t_acc'(2 * w_q0 - 5 * w_q1 + 4 * w_q2 - w_q3);
        n_b2 = crle_pkg::t_acc'(2 * n_b);
        n_c  = crle_pkg::t_acc'(w_q2 - w_q0);
        n_p2 = crle_pkg::t_acc'(2 * w_q1);
    end

    assign w_f1 = $signed({1'b0, r1_frac});
    assign w_f2 = $signed({1'b0, r2_frac});
    assign w_f3 = $signed({1'b0, r3_frac});

    assign n_hb = crle_pkg::round16(r2_pa) + r2_b;
    assign n_gb = crle_pkg::round16(r2_ga) + r2_b2;
    assign n_hc = crle_pkg::round16(r3_pb) + r3_c;
    assign n_h  = crle_pkg::round16(r4_pc) + r4_p2;

    always_ff @(posedge i_clk) begin
        r1_a    <= n_a;
        r1_a3   <= n_a3;
        r1_b    <= n_b;
        r1_b2   <= n_b2;
        r1_c    <= n_c;
        r1_p2   <= n_p2;
        r1_frac <= i_frac;

        r2_pa   <= crle_pkg::t_prod'(r1_a) * crle_pkg::t_prod'(w_f1);
        r2_ga   <= crle_pkg::t_prod'(r1_a3) * crle_pkg::t_prod'(w_f1);
        r2_b    <= r1_b;
        r2_b2   <= r1_b2;
        r2_c    <= r1_c;
        r2_p2   <= r1_p2;
        r2_frac <= r1_frac;

        r3_pb   <= crle_pkg::t_prod'(n_hb) * crle_pkg::t_prod'(w_f2);
        r3_gb   <= crle_pkg::t_prod'(n_gb) * crle_pkg::t_prod'(w_f2);
        r3_c    <= r2_c;
        r3_p2   <= r2_p2;
        r3_frac <= r2_frac;

        r4_pc   <= crle_pkg::t_prod'(n_hc) * crle_pkg::t_prod'(w_f3);
        r4_g    <= crle_pkg::round16(r3_gb) + r3_c;
        r4_p2   <= r3_p2;

        // the halved 22-bit result always fits the Q23.0 (signed 24-bit integer) output, so no clamp is needed
        r5_pos  <= crle_pkg::half_up(n_h);
        r5_der  <= crle_pkg::half_up(r4_g);
    end

    assign o_pos = r5_pos;
    assign o_der = r5_der;

endmodule

[rtl/catmull_rom_loop_evaluator.sv]
// ----------------------------------------------------------------------------
// catmull_rom_loop_evaluator
// Uniform Catmull-Rom evaluation over closed loops of 3-D control points.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge where start is high and busy is
// low; busy is high only during reset and until the ready register sets after
// it. Write transactions (i_cmd = 0) store one control point and give no
// result; they are seen by evaluations taken on the next cycle onward.
// Evaluate transactions (i_cmd = 1) give one result each, in order, marked
// by o_valid for a single cycle. One transaction per cycle is sustained: a
// seven-stage pipeline (segment select, point-store read, coefficient
// forming, three Horner multiply stages and the output register), with the
// point store kept in four RAM copies so the four control points of a
// segment are read in parallel. There is no result backpressure. An evaluate
// on a curve beyond the curve count returns all zeros; reading a slot never
// written returns undefined values. Out-of-range writes are ignored.
// ----------------------------------------------------------------------------
module catmull_rom_loop_evaluator #(
    parameter int LOOP_POINTS = crle_pkg::LOOP_POINTS_DEF,
    parameter int CURVE_COUNT = crle_pkg::CURVE_COUNT_DEF,
    parameter int COORD_BITS  = crle_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [crle_pkg::CURVE_BITS-1:0] i_curve,
    input  logic [crle_pkg::SLOT_BITS-1:0]  i_point_index,
    input  logic signed [15:0]              i_coord_x,
    input  logic signed [15:0]              i_coord_y,
    input  logic signed [15:0]              i_coord_z,
    input  logic [15:0]                     i_global_t,
    output logic                            o_valid,
    output logic signed [23:0]              o_pos_x,
    output logic signed [23:0]              o_pos_y,
    output logic signed [23:0]              o_pos_z,
    output logic signed [23:0]              o_der_x,
    output logic signed [23:0]              o_der_y,
    output logic signed [23:0]              o_der_z
);

    localparam int LAST = crle_pkg::LANE_LAT - 1;

    logic                        r_ready;
    logic                        w_accept;
    crle_pkg::t_coord            w_coord [3];
    crle_pkg::t_ctrl             w_fctrl;
    logic [crle_pkg::FRAC_W-1:0] w_frac;
    crle_pkg::t_coord            w_pt [4][3];
    crle_pkg::t_out              w_pos [3];
    crle_pkg::t_out              w_der [3];
    crle_pkg::t_ctrl             r_ctrl [crle_pkg::LANE_LAT];
    logic                        w_zero;

    assign busy     = !r_ready;
    assign w_accept = start && !busy;
    assign w_coord[0] = i_coord_x;
    assign w_coord[1] = i_coord_y;
    assign w_coord[2] = i_coord_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    crle_fetch #(
        .LOOP_POINTS (LOOP_POINTS),
        .CURVE_COUNT (CURVE_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_fetch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd),
        .i_curve       (i_curve),
        .i_point_index (i_point_index),
        .i_coord       (w_coord),
        .i_global_t    (i_global_t),
        .o_ctrl        (w_fctrl),
        .o_frac        (w_frac),
        .o_pt          (w_pt)
    );

    for (genvar c = 0; c < 3; c++) begin : g_lane
        crle_lane u_lane (
            .i_clk  (i_clk),
            .i_p0   (w_pt[0][c]),
            .i_p1   (w_pt[1][c]),
            .i_p2   (w_pt[2][c]),
            .i_p3   (w_pt[3][c]),
            .i_frac (w_frac),
            .o_pos  (w_pos[c]),
            .o_der  (w_der[c])
        );
    end

    // advance the control flags alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < crle_pkg::LANE_LAT; k++) begin
                r_ctrl[k] <= '0;
            end
        end else begin
            r_ctrl[0] <= w_fctrl;
            for (int k = 1; k < crle_pkg::LANE_LAT; k++) begin
                r_ctrl[k] <= r_ctrl[k-1];
            end
        end
    end

    assign w_zero  = r_ctrl[LAST].zero;
    assign o_valid = r_ctrl[LAST].valid;
    assign o_pos_x = w_zero ? '0 : w_pos[0];
    assign o_pos_y = w_zero ? '0 : w_pos[1];
    assign o_pos_z = w_zero ? '0 : w_pos[2];
    assign o_der_x = w_zero ? '0 : w_der[0];
    assign o_der_y = w_zero ? '0 : w_der[1];
    assign o_der_z = w_zero ? '0 : w_der[2];

    a_result_from_eval : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept && (i_cmd == crle_pkg::CMD_EVAL), crle_pkg::TOTAL_LAT))
        else $error("result strobe without a matching evaluate transaction");

    a_eval_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_ready, crle_pkg::TOTAL_LAT) &&
        $past(w_accept && (i_cmd == crle_pkg::CMD_EVAL), crle_pkg::TOTAL_LAT) |-> o_valid)
        else $error("evaluate transaction lost in the pipeline");

    a_bad_curve_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(5'(i_curve) >= 5'(CURVE_COUNT), crle_pkg::TOTAL_LAT) |->
        (o_pos_x == '0) && (o_pos_y == '0) && (o_pos_z == '0) &&
        (o_der_x == '0) && (o_der_y == '0) && (o_der_z == '0))
        else $error("out-of-range curve gave a nonzero result");

    a_busy_after_reset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset recovery");

endmodule
